[rtl/core/mts_pkg.sv]
package mts_pkg;

   localparam int NOTE_DEPTH = 256;
   localparam int NOTE_AW    = $clog2(NOTE_DEPTH);

   localparam int LEN_W      = 9;
   localparam int TEMPO_W    = 16;
   localparam int WORD_W     = 16;
   localparam int FREQ_W     = 12;
   localparam int COUNT_W    = 4;
   localparam int CLK_W      = 22;
   localparam int PRESC_W    = 18;
   localparam int TICKS_W    = 20;
   localparam int POS_W      = 8;

   localparam int DIV_STEPS  = CLK_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [FREQ_W-1:0]  FREQ_MIN_EXCL = FREQ_W'(12'h012);
   localparam logic [TEMPO_W-1:0] TEMPO_AT_REST = TEMPO_W'(100);
   localparam logic [CLK_W-1:0]   CLOCK_RESET   = CLK_W'(1680000);

   typedef enum logic [2:0] {
      REQ_TICK  = 3'd0,
      REQ_WRITE = 3'd1,
      REQ_START = 3'd2,
      REQ_STOP  = 3'd3,
      REQ_MUTE  = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_NOTE,
      ST_DIV,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic              start;
      logic [CLK_W-1:0]  dividend;
      logic [FREQ_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [CLK_W-1:0]  quotient;
   } div_rsp_type;

endpackage

[rtl/core/mts_divider.sv]
module mts_divider
   import mts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [FREQ_W-1:0]    rem_ff, rem_in;
   logic [CLK_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [FREQ_W:0]      trial;
   logic [FREQ_W:0]      diff;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[CLK_W-1]};
      diff   = trial - {1'b0, div_req.divisor};
      fits   = (trial >= {1'b0, div_req.divisor});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
         quo_in = {quo_ff[CLK_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/core/melody_tone_sequencer.sv]
// Melody player with tone timer control. A request transfer carries one command:
// a one-millisecond tick, a note write into the 256-entry note memory, a start
// (length, tempo, repeat), a stop, or a mute setting; each request returns exactly
// one status transfer (tone on, prescaler, playing, note position). A request that
// loads a sounding note waits on the 22-step restoring divider, which forms clock/100
// divided by the note frequency one quotient bit per cycle; other requests skip it.
// The block is not ready while a request is in work, and takes the next request
// while the previous response still waits in its output register. The clock
// register may be written at any time the block is idle.
module melody_tone_sequencer
   import mts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [21:0] csr_wdata,   // clock_div_hundred
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // entry_index, entry_word, melody_length,
                                    // tempo_ms, repeat_flag, mute_setting
   input  logic [2:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // tone_on, prescaler, playing, note_position
);

   state_type state_ff, state_in;

   logic [CLK_W-1:0]   clk_div_ff;
   logic [2:0]         kind_ff;
   logic [7:0]         index_ff;
   logic [WORD_W-1:0]  word_ff;
   logic [LEN_W-1:0]   req_len_ff;
   logic [TEMPO_W-1:0] req_tempo_ff;
   logic               req_rep_ff;
   logic               req_mute_ff;

   logic [NOTE_AW-1:0] position_ff, position_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [TEMPO_W-1:0] tempo_ff, tempo_in;
   logic               repeat_ff, repeat_in;
   logic               playing_ff, playing_in;
   logic               mute_ff, mute_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic               tone_ff, tone_in;
   logic [PRESC_W-1:0] presc_ff, presc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   logic [WORD_W-1:0]  note_mem [NOTE_DEPTH];
   logic [WORD_W-1:0]  rd_word_ff;
   logic               mem_we;

   logic               accept;
   logic [NOTE_AW:0]   pos_next;
   logic [FREQ_W-1:0]  freq;
   logic [COUNT_W-1:0] count;
   logic [TICKS_W-1:0] product;
   logic [POS_W-1:0]   pos_out;

   div_req_type div_req;
   div_rsp_type div_rsp;

   mts_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pos_next = {1'b0, position_ff} + (NOTE_AW + 1)'(1);
   assign freq     = rd_word_ff[WORD_W-1:COUNT_W];
   assign count    = rd_word_ff[COUNT_W-1:0];
   assign product  = TICKS_W'(tempo_ff) * TICKS_W'(count);
   assign pos_out  = playing_ff ? POS_W'(position_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      position_in  = position_ff;
      length_in    = length_ff;
      tempo_in     = tempo_ff;
      repeat_in    = repeat_ff;
      playing_in   = playing_ff;
      mute_in      = mute_ff;
      ticks_in     = ticks_ff;
      tone_in      = tone_ff;
      presc_in     = presc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = clk_div_ff;
      div_req.divisor  = freq;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESPOND;
            case (kind_ff)
               REQ_TICK: begin
                  if (playing_ff) begin
                     if (ticks_ff > TICKS_W'(1)) begin
                        ticks_in = ticks_ff - TICKS_W'(1);
                     end else if (LEN_W'(pos_next) >= length_ff) begin
                        if (repeat_ff) begin
                           position_in = '0;
                           state_in    = ST_READ;
                        end else begin
                           playing_in  = 1'b0;
                           length_in   = '0;
                           position_in = '0;
                           tempo_in    = TEMPO_AT_REST;
                           repeat_in   = 1'b0;
                           ticks_in    = '0;
                           tone_in     = 1'b0;
                           presc_in    = '0;
                        end
                     end else begin
                        position_in = pos_next[NOTE_AW-1:0];
                        state_in    = ST_READ;
                     end
                  end
               end
               REQ_WRITE: begin
                  mem_we = (32'(index_ff) < NOTE_DEPTH);
               end
               REQ_START: begin
                  if (req_len_ff != '0 && req_tempo_ff != '0) begin
                     length_in   = (32'(req_len_ff) > NOTE_DEPTH) ?
                                   LEN_W'(NOTE_DEPTH) : req_len_ff;
                     tempo_in    = req_tempo_ff;
                     repeat_in   = req_rep_ff;
                     position_in = '0;
                     playing_in  = 1'b1;
                     state_in    = ST_READ;
                  end
               end
               REQ_STOP: begin
                  playing_in  = 1'b0;
                  length_in   = '0;
                  position_in = '0;
                  tempo_in    = TEMPO_AT_REST;
                  repeat_in   = 1'b0;
                  ticks_in    = '0;
                  tone_in     = 1'b0;
                  presc_in    = '0;
               end
               REQ_MUTE: begin
                  mute_in = req_mute_ff;
                  if (req_mute_ff) begin
                     tone_in  = 1'b0;
                     presc_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            state_in = ST_NOTE;
         end
         ST_NOTE: begin
            ticks_in = (product == '0) ? TICKS_W'(1) : product;
            if (freq > FREQ_MIN_EXCL && !mute_ff) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               tone_in  = 1'b0;
               presc_in = '0;
               state_in = ST_RESPOND;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               tone_in  = 1'b1;
               presc_in = div_rsp.quotient[PRESC_W-1:0];
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, pos_out, playing_ff,
                               tone_ff ? presc_ff : PRESC_W'(0), tone_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_div_ff   <= CLOCK_RESET;
         position_ff  <= '0;
         length_ff    <= '0;
         tempo_ff     <= TEMPO_AT_REST;
         repeat_ff    <= 1'b0;
         playing_ff   <= 1'b0;
         mute_ff      <= 1'b0;
         ticks_ff     <= '0;
         tone_ff      <= 1'b0;
         presc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            clk_div_ff <= csr_wdata;
         end
         position_ff  <= position_in;
         length_ff    <= length_in;
         tempo_ff     <= tempo_in;
         repeat_ff    <= repeat_in;
         playing_ff   <= playing_in;
         mute_ff      <= mute_in;
         ticks_ff     <= ticks_in;
         tone_ff      <= tone_in;
         presc_ff     <= presc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         kind_ff      <= req_tuser;
         index_ff     <= req_tdata[7:0];
         word_ff      <= req_tdata[23:8];
         req_len_ff   <= req_tdata[32:24];
         req_tempo_ff <= req_tdata[48:33];
         req_rep_ff   <= req_tdata[49];
         req_mute_ff  <= req_tdata[50];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[index_ff[NOTE_AW-1:0]] <= word_ff;
      end
      rd_word_ff <= note_mem[position_ff];
   end

`ifndef SYNTHESIS
   a_tone_needs_play: assert property (@(posedge clock) disable iff (reset)
      tone_ff |-> playing_ff)
      else $error("tone running without an active melody");

   a_tone_not_muted: assert property (@(posedge clock) disable iff (reset)
      tone_ff |-> !mute_ff)
      else $error("tone running while muted");

   a_idle_position: assert property (@(posedge clock) disable iff (reset)
      !playing_ff |-> (position_ff == '0 && length_ff == '0))
      else $error("stale position or length while stopped");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> (LEN_W'(position_ff) < length_ff))
      else $error("note position beyond melody length");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on an idle divider");
`endif

endmodule
